### rtl/ows_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ows_pkg
// Shared constants, codes and types of the one-wire search-ROM engine.
// ----------------------------------------------------------------------------
package ows_pkg;

	localparam int ROM_BITS   = 64;
	localparam int ROM_CODE_W = 64;
	localparam int POS_W      = $clog2(ROM_BITS + 1);
	localparam int IDX_W      = $clog2(ROM_BITS);

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_PAIR  = 2'd2;

	localparam logic [2:0] ST_CHOSEN   = 3'd0;
	localparam logic [2:0] ST_FOUND    = 3'd1;
	localparam logic [2:0] ST_NODEV    = 3'd2;
	localparam logic [2:0] ST_FINISHED = 3'd3;
	localparam logic [2:0] ST_STARTED  = 3'd4;
	localparam logic [2:0] ST_IGNORED  = 3'd5;

	typedef struct packed {
		logic [POS_W-1:0]    disc;
		logic                fin;
		logic [ROM_BITS-1:0] prev;
		logic [ROM_BITS-1:0] build;
		logic [POS_W-1:0]    pos;
		logic [POS_W-1:0]    lastz;
		logic                open;
	} search_t;

	typedef struct packed {
		logic                  emit;
		logic [2:0]            status;
		logic                  dir;
		logic [ROM_CODE_W-1:0] rom;
		logic                  last;
	} result_t;

endpackage
`default_nettype wire

### rtl/ows_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ows_step
// Next search state and result for one item, from the current state.
// ----------------------------------------------------------------------------
module ows_step import ows_pkg::*; (
	input  wire search_t    cur,
	input  wire logic [1:0] command,
	input  wire logic       presence_ok,
	input  wire logic       id_bit,
	input  wire logic       complement_bit,
	output search_t         nxt,
	output result_t         res
);

	logic [IDX_W-1:0]    idx;
	logic                dir;
	logic [POS_W-1:0]    lastz_new;
	logic [ROM_BITS-1:0] build_new;
	logic                fin_new;

	always_comb begin
		nxt       = cur;
		res       = '0;
		idx       = IDX_W'(cur.pos - POS_W'(1));
		dir       = 1'b0;
		lastz_new = cur.lastz;
		build_new = cur.build;
		fin_new   = 1'b0;
		case (command)
			CMD_CLEAR: begin
				nxt.disc = '0;
				nxt.fin  = 1'b0;
				nxt.prev = '0;
				nxt.open = 1'b0;
			end
			CMD_START: begin
				res.emit = 1'b1;
				if (cur.fin) begin
					nxt.open   = 1'b0;
					res.status = ST_FINISHED;
				end else if (!presence_ok) begin
					nxt.disc   = '0;
					nxt.fin    = 1'b0;
					nxt.open   = 1'b0;
					res.status = ST_NODEV;
				end else begin
					nxt.pos    = POS_W'(1);
					nxt.lastz  = '0;
					nxt.build  = '0;
					nxt.open   = 1'b1;
					res.status = ST_STARTED;
				end
			end
			CMD_PAIR: begin
				res.emit = 1'b1;
				if (!cur.open) begin
					res.status = ST_IGNORED;
				end else if (id_bit && complement_bit) begin
					nxt.disc   = '0;
					nxt.fin    = 1'b0;
					nxt.open   = 1'b0;
					res.status = ST_NODEV;
				end else begin
					if (!id_bit && !complement_bit) begin
						if (cur.pos < cur.disc) begin
							dir = cur.prev[idx];
						end else if (cur.pos == cur.disc) begin
							dir = 1'b1;
						end else begin
							dir       = 1'b0;
							lastz_new = cur.pos;
						end
					end else begin
						dir = id_bit;
					end
					build_new[idx] = build_new[idx] | dir;
					nxt.build      = build_new;
					nxt.lastz      = lastz_new;
					res.dir        = dir;
					if (cur.pos >= POS_W'(ROM_BITS)) begin
						fin_new    = (lastz_new == '0);
						nxt.disc   = lastz_new;
						nxt.fin    = fin_new;
						nxt.prev   = build_new;
						nxt.open   = 1'b0;
						nxt.pos    = POS_W'(1);
						res.status = ST_FOUND;
						res.rom    = ROM_CODE_W'(build_new);
						res.last   = fin_new;
					end else begin
						nxt.pos    = cur.pos + POS_W'(1);
						res.status = ST_CHOSEN;
					end
				end
			end
			default: begin
				res.emit   = 1'b1;
				res.status = ST_IGNORED;
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/onewire_rom_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_rom_search
// One-wire search-ROM engine: picks the direction bit for each id/complement
// pair and reports each ROM found across successive search passes.
// ----------------------------------------------------------------------------
// Takes one item per clock while not stalled. An accepted item updates the
// search state and, except for a clear, loads one result into the output
// register on the same edge; the result appears in the cycle after
// acceptance, from the single combinational pass through ows_step between
// the state and output registers. A waiting result is held while stalled,
// and a new item is taken in the same cycle the old result leaves.
module onewire_rom_search import ows_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            command,
	input  wire logic                  presence_ok,
	input  wire logic                  id_bit,
	input  wire logic                  complement_bit,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [2:0]                 status,
	output logic                       direction_bit,
	output logic [ROM_CODE_W-1:0]      rom_code,
	output logic                       last_device
);

	localparam search_t STATE_RESET = '{disc: '0, fin: 1'b0, prev: '0, build: '0,
		pos: POS_W'(1), lastz: '0, open: 1'b0};

	search_t state_q;
	search_t state_nxt;
	result_t res;
	logic    out_valid_q;
	logic    in_accept;

	ows_step u_step (
		.cur            (state_q),
		.command        (command),
		.presence_ok    (presence_ok),
		.id_bit         (id_bit),
		.complement_bit (complement_bit),
		.nxt            (state_nxt),
		.res            (res)
	);

	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= STATE_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_accept) begin
				state_q <= state_nxt;
			end
			if (in_accept) begin
				out_valid_q <= res.emit;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && res.emit) begin
			status        <= res.status;
			direction_bit <= res.dir;
			rom_code      <= res.rom;
			last_device   <= res.last;
		end
	end

	assign out_valid = out_valid_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.open |-> (state_q.pos >= POS_W'(1)) && (state_q.pos <= POS_W'(ROM_BITS)))
		else $error("bit position out of range while a pass is open");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && command == CMD_CLEAR |=>
			state_q.disc == '0 && !state_q.fin && !state_q.open && state_q.prev == '0)
		else $error("clear did not reset search state");

	a_found_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FOUND |-> !state_q.open)
		else $error("pass still open after rom found");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_CHOSEN && status != ST_FOUND |->
			!direction_bit && rom_code == '0 && !last_device)
		else $error("unused result fields not zero");

endmodule
`default_nettype wire
